FILE: rtl/core/lc2k_pkg.sv
package lc2k_pkg;

    // Word memory geometry; the 12-bit address ports fix the depth
    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = 12;
    localparam int NUM_REGS  = 8;
    localparam int REG_AW    = 3;

    // Request codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_EXEC  = 2'd1;
    localparam logic [1:0] FUNC_RDMEM = 2'd2;
    localparam logic [1:0] FUNC_RDREG = 2'd3;

    // Result status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_HALTED   = 3'd1;
    localparam logic [2:0] STAT_UNKNOWN  = 3'd2;
    localparam logic [2:0] STAT_STOPPED  = 3'd3;
    localparam logic [2:0] STAT_PAST_END = 3'd4;

    // Opcodes (instruction bits 31:22)
    localparam logic [9:0] OP_ADD  = 10'd0;
    localparam logic [9:0] OP_NOR  = 10'd1;
    localparam logic [9:0] OP_LW   = 10'd2;
    localparam logic [9:0] OP_SW   = 10'd3;
    localparam logic [9:0] OP_BEQ  = 10'd4;
    localparam logic [9:0] OP_JALR = 10'd5;
    localparam logic [9:0] OP_HALT = 10'd6;
    localparam logic [9:0] OP_NOOP = 10'd7;

    // Configuration register index (paddr bit 2)
    localparam logic REG_PROG_WORDS = 1'b0;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [31:0]       wdata;
        logic              re;
        logic [MEM_AW-1:0] raddr;
    } t_wm_req;

    typedef struct packed {
        logic              re;
        logic [REG_AW-1:0] ra;
        logic [REG_AW-1:0] rb;
        logic              we;
        logic [REG_AW-1:0] wa;
        logic [31:0]       wd;
    } t_rf_req;

endpackage

FILE: rtl/core/lc2k_instruction_executor.sv
// Load word and stopped/past-end execute requests answer in the cycle after they are
// accepted; memory and register reads pass through a read state; execute steps through
// fetch, register read and execute states, and lw adds a load state. Transactions do
// not overlap: a new one may start in the cycle the result strobe is high.
// Reset (synchronous, active low) clears pc, stopped flag, count, program_words and
// register file; word memory content is undefined until written. Results cannot stall.
module lc2k_instruction_executor
    import lc2k_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_func,
    input  logic [11:0]        i_addr,
    input  logic signed [31:0] i_data,
    // result channel
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic [11:0]        o_pc,
    output logic signed [31:0] o_read_data,
    output logic               o_reg_written,
    output logic [2:0]         o_reg_index,
    output logic signed [31:0] o_reg_value,
    output logic               o_mem_written,
    output logic [11:0]        o_mem_addr,
    output logic [31:0]        o_instr_count,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RDMEM  = 3'd1;
    localparam logic [2:0] ST_RDREG  = 3'd2;
    localparam logic [2:0] ST_DECODE = 3'd3;
    localparam logic [2:0] ST_EXEC   = 3'd4;
    localparam logic [2:0] ST_LOAD   = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [MEM_AW-1:0] r_pc, n_pc;
    logic              r_stopped, n_stopped;
    logic [31:0]       r_count, n_count;
    logic [12:0]       r_prog_words;
    logic [REG_AW-1:0] r_dst, n_dst;

    // Result registers
    logic              r_done, n_done;
    logic [2:0]        r_status, n_status;
    logic [31:0]       r_read_data, n_read_data;
    logic              r_rw, n_rw;
    logic [REG_AW-1:0] r_ridx, n_ridx;
    logic [31:0]       r_rval, n_rval;
    logic              r_mw, n_mw;
    logic [MEM_AW-1:0] r_maddr, n_maddr;

    t_wm_req     wm_req;
    t_rf_req     rf_req;
    logic [31:0] wm_rdata;
    logic [31:0] rf_rdata_a;
    logic [31:0] rf_rdata_b;

    logic              accept;
    logic              cfg_write;
    logic [9:0]        op;
    logic [REG_AW-1:0] fld_ra, fld_rb, fld_rd;
    logic [31:0]       offset;
    logic [31:0]       eff_sum;
    logic [MEM_AW-1:0] pc_inc;

    lc2k_word_mem u_word_mem (
        .i_clk   (i_clk),
        .i_req   (wm_req),
        .o_rdata (wm_rdata)
    );

    lc2k_reg_file u_reg_file (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (rf_req),
        .o_rdata_a (rf_rdata_a),
        .o_rdata_b (rf_rdata_b)
    );

    assign o_busy = (r_state != ST_IDLE);
    assign accept = i_start && !o_busy;

    // Configuration: one register, program_words, at byte address 0
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_PROG_WORDS) ? {19'b0, r_prog_words} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_words <= '0;
        end else if (cfg_write && paddr[2] == REG_PROG_WORDS) begin
            r_prog_words <= pwdata[12:0];
        end
    end

    // Instruction fields come straight off the memory read register: it holds the
    // fetched word through decode and execute since no other read is issued then.
    assign op      = wm_rdata[31:22];
    assign fld_ra  = wm_rdata[21:19];
    assign fld_rb  = wm_rdata[18:16];
    assign fld_rd  = wm_rdata[2:0];
    assign offset  = {{16{wm_rdata[15]}}, wm_rdata[15:0]};
    assign eff_sum = rf_rdata_a + offset;
    assign pc_inc  = r_pc + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_stopped   = r_stopped;
        n_count     = r_count;
        n_dst       = r_dst;
        n_done      = 1'b0;
        n_status    = STAT_OK;
        n_read_data = '0;
        n_rw        = 1'b0;
        n_ridx      = '0;
        n_rval      = '0;
        n_mw        = 1'b0;
        n_maddr     = '0;
        wm_req      = '0;
        rf_req      = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_func)
                        FUNC_LOAD: begin
                            wm_req.we    = 1'b1;
                            wm_req.waddr = i_addr;
                            wm_req.wdata = $unsigned(i_data);
                            n_done       = 1'b1;
                        end
                        FUNC_EXEC: begin
                            if (r_stopped) begin
                                n_status = STAT_STOPPED;
                                n_done   = 1'b1;
                            end else if ({1'b0, r_pc} > r_prog_words) begin
                                // Drop execution for good once pc runs off the program
                                n_stopped = 1'b1;
                                n_status  = STAT_PAST_END;
                                n_done    = 1'b1;
                            end else begin
                                // Fetch
                                wm_req.re    = 1'b1;
                                wm_req.raddr = r_pc;
                                n_state      = ST_DECODE;
                            end
                        end
                        FUNC_RDMEM: begin
                            wm_req.re    = 1'b1;
                            wm_req.raddr = i_addr;
                            n_state      = ST_RDMEM;
                        end
                        FUNC_RDREG: begin
                            rf_req.re = 1'b1;
                            rf_req.ra = i_addr[REG_AW-1:0];
                            n_state   = ST_RDREG;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RDMEM: begin
                n_read_data = wm_rdata;
                n_done      = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_RDREG: begin
                n_read_data = rf_rdata_a;
                n_done      = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_DECODE: begin
                // Read both source registers
                rf_req.re = 1'b1;
                rf_req.ra = fld_ra;
                rf_req.rb = fld_rb;
                n_state   = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                n_pc    = pc_inc;
                n_count = (r_count != '1) ? r_count + 32'd1 : r_count;
                case (op)
                    OP_ADD: begin
                        n_rw   = 1'b1;
                        n_ridx = fld_rd;
                        n_rval = rf_rdata_a + rf_rdata_b;
                    end
                    OP_NOR: begin
                        n_rw   = 1'b1;
                        n_ridx = fld_rd;
                        n_rval = ~(rf_rdata_a | rf_rdata_b);
                    end
                    OP_LW: begin
                        // Hold the result until the data word returns
                        wm_req.re    = 1'b1;
                        wm_req.raddr = eff_sum[MEM_AW-1:0];
                        n_dst        = fld_rb;
                        n_state      = ST_LOAD;
                        n_done       = 1'b0;
                    end
                    OP_SW: begin
                        wm_req.we    = 1'b1;
                        wm_req.waddr = eff_sum[MEM_AW-1:0];
                        wm_req.wdata = rf_rdata_b;
                        n_mw         = 1'b1;
                        n_maddr      = eff_sum[MEM_AW-1:0];
                    end
                    OP_BEQ: begin
                        if (rf_rdata_a == rf_rdata_b) begin
                            n_pc = pc_inc + offset[MEM_AW-1:0];
                        end
                    end
                    OP_JALR: begin
                        n_rw   = 1'b1;
                        n_ridx = fld_rb;
                        n_rval = {19'b0, {1'b0, r_pc} + 13'd1};
                        // regB is written first, so a shared register jumps to pc+1
                        n_pc   = (fld_ra == fld_rb) ? pc_inc : rf_rdata_a[MEM_AW-1:0];
                    end
                    OP_HALT: begin
                        n_stopped = 1'b1;
                        n_status  = STAT_HALTED;
                    end
                    OP_NOOP: begin
                        n_status = STAT_OK;
                    end
                    default: begin
                        n_status = STAT_UNKNOWN;
                    end
                endcase
                rf_req.we = n_rw;
                rf_req.wa = n_ridx;
                rf_req.wd = n_rval;
            end
            ST_LOAD: begin
                n_rw      = 1'b1;
                n_ridx    = r_dst;
                n_rval    = wm_rdata;
                rf_req.we = 1'b1;
                rf_req.wa = r_dst;
                rf_req.wd = wm_rdata;
                n_done    = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pc      <= '0;
            r_stopped <= 1'b0;
            r_count   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_stopped <= n_stopped;
            r_count   <= n_count;
            r_done    <= n_done;
        end
    end

    // Result payload and load destination; no reset needed
    always_ff @(posedge i_clk) begin
        r_dst <= n_dst;
        if (n_done) begin
            r_status    <= n_status;
            r_read_data <= n_read_data;
            r_rw        <= n_rw;
            r_ridx      <= n_ridx;
            r_rval      <= n_rval;
            r_mw        <= n_mw;
            r_maddr     <= n_maddr;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_pc          = r_pc;
    assign o_read_data   = $signed(r_read_data);
    assign o_reg_written = r_rw;
    assign o_reg_index   = r_ridx;
    assign o_reg_value   = $signed(r_rval);
    assign o_mem_written = r_mw;
    assign o_mem_addr    = r_maddr;
    assign o_instr_count = r_count;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while sequencer busy");

    a_stopped_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_func == FUNC_EXEC && r_stopped |=> o_done && o_status == STAT_STOPPED)
        else $error("stopped core did not answer at once");

    a_stopped_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared without reset");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_reg_written && o_mem_written))
        else $error("instruction wrote both register and memory");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_func != FUNC_EXEC |=> $stable(r_count))
        else $error("instruction count moved on a non-execute transaction");
`endif

endmodule

FILE: rtl/core/lc2k_word_mem.sv
module lc2k_word_mem
    import lc2k_pkg::*;
(
    input  logic        i_clk,
    input  t_wm_req     i_req,
    output logic [31:0] o_rdata
);

    logic [31:0] r_mem [MEM_WORDS];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lc2k_reg_file.sv
module lc2k_reg_file
    import lc2k_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rf_req     i_req,
    output logic [31:0] o_rdata_a,
    output logic [31:0] o_rdata_b
);

    logic [31:0]         r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [31:0]         r_rdata_a;
    logic [31:0]         r_rdata_b;

    // Entries not yet written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wa] <= i_req.wd;
        end
        if (i_req.re) begin
            r_rdata_a <= r_valid[i_req.ra] ? r_mem[i_req.ra] : '0;
            r_rdata_b <= r_valid[i_req.rb] ? r_mem[i_req.rb] : '0;
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: test/testbench.sv
// Self-checking bench for lc2k_instruction_executor.
//
// A shadow copy of the LC-2K core (memory, register file, pc, stopped flag and
// executed count) runs in lockstep with the command transactions. Each
// accepted command pushes its predicted result, and the result checker
// compares every strobed result field by field with the oldest prediction.
//
// The stopped flag clears only on reset, and reset happens once. Random
// programs therefore never contain halt, and program_words is raised before
// pc can pass it. The last test stops the core once, by halt or by running
// past the program end (chosen at random), and then checks the stopped
// answers.
//
// Memory words that were never written are never fetched or read: before
// each execute, the bench loads an instruction at pc when none is there, and
// a data word at the lw address when that word is empty.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lc2k_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          PRINT_LIMIT = 40;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] pc;
        logic [31:0] read_data;
        logic        reg_written;
        logic [2:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_written;
        logic [11:0] mem_addr;
        logic [31:0] instr_count;
    } t_core_result;

    // DUT connections; every input starts at a known value
    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [1:0]         i_func  = '0;
    logic [11:0]        i_addr  = '0;
    logic signed [31:0] i_data  = '0;
    logic               o_done;
    logic [2:0]         o_status;
    logic [11:0]        o_pc;
    logic signed [31:0] o_read_data;
    logic               o_reg_written;
    logic [2:0]         o_reg_index;
    logic signed [31:0] o_reg_value;
    logic               o_mem_written;
    logic [11:0]        o_mem_addr;
    logic [31:0]        o_instr_count;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [2:0]         paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Shadow core state
    logic [31:0] shadow_mem [MEM_WORDS];
    bit          shadow_mem_set [MEM_WORDS];
    logic [31:0] shadow_regs [NUM_REGS];
    logic [11:0] shadow_pc;
    logic        shadow_stopped;
    logic [31:0] shadow_count;
    logic [12:0] shadow_prog_words;

    t_core_result pending_results[$];

    int          fault_count   = 0;
    int          cmds_sent     = 0;
    int          length_writes = 0;
    int          status_tally [5];
    bit          gaps_enabled  = 1'b1;
    int unsigned cycle_count   = 0;

    lc2k_instruction_executor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_func        (i_func),
        .i_addr        (i_addr),
        .i_data        (i_data),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_pc          (o_pc),
        .o_read_data   (o_read_data),
        .o_reg_written (o_reg_written),
        .o_reg_index   (o_reg_index),
        .o_reg_value   (o_reg_value),
        .o_mem_written (o_mem_written),
        .o_mem_addr    (o_mem_addr),
        .o_instr_count (o_instr_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: end the run if the core stops answering
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fault_count++;
        if (fault_count <= PRINT_LIMIT)
            $display("ERROR t=%0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    function automatic logic [31:0] encode(input logic [9:0] op, input logic [2:0] ra,
                                           input logic [2:0] rb, input logic [15:0] low);
        return {op, ra, rb, low};
    endfunction

    // Advance the shadow core by one command and return the result it must produce.
    function automatic t_core_result predict_core_step(input logic [1:0] func,
                                                       input logic [11:0] addr,
                                                       input logic [31:0] data);
        t_core_result r;
        logic [31:0]  word;
        logic [31:0]  offset;
        logic [31:0]  nxt;
        logic [31:0]  ea;
        logic [9:0]   op;
        logic [2:0]   ra;
        logic [2:0]   rb;
        r = '0;
        case (func)
            FUNC_LOAD: begin
                shadow_mem[addr]     = data;
                shadow_mem_set[addr] = 1'b1;
            end
            FUNC_RDMEM: r.read_data = shadow_mem[addr];
            FUNC_RDREG: r.read_data = shadow_regs[addr[2:0]];
            default: begin
                if (shadow_stopped) begin
                    r.status = STAT_STOPPED;
                end else if ({1'b0, shadow_pc} > shadow_prog_words) begin
                    shadow_stopped = 1'b1;
                    r.status       = STAT_PAST_END;
                end else begin
                    word   = shadow_mem[shadow_pc];
                    op     = word[31:22];
                    ra     = word[21:19];
                    rb     = word[18:16];
                    offset = {{16{word[15]}}, word[15:0]};
                    nxt    = {20'd0, shadow_pc} + 32'd1;
                    case (op)
                        OP_ADD: begin
                            r.reg_written = 1'b1;
                            r.reg_index   = word[2:0];
                            r.reg_value   = shadow_regs[ra] + shadow_regs[rb];
                        end
                        OP_NOR: begin
                            r.reg_written = 1'b1;
                            r.reg_index   = word[2:0];
                            r.reg_value   = ~(shadow_regs[ra] | shadow_regs[rb]);
                        end
                        OP_LW: begin
                            ea            = shadow_regs[ra] + offset;
                            r.reg_written = 1'b1;
                            r.reg_index   = rb;
                            r.reg_value   = shadow_mem[ea[11:0]];
                        end
                        OP_SW: begin
                            ea                         = shadow_regs[ra] + offset;
                            r.mem_written              = 1'b1;
                            r.mem_addr                 = ea[11:0];
                            shadow_mem[ea[11:0]]       = shadow_regs[rb];
                            shadow_mem_set[ea[11:0]]   = 1'b1;
                        end
                        OP_BEQ: begin
                            if (shadow_regs[ra] == shadow_regs[rb])
                                nxt = {20'd0, shadow_pc} + offset + 32'd1;
                        end
                        OP_JALR: begin
                            // link first: with ra == rb the jump lands on pc+1
                            r.reg_written   = 1'b1;
                            r.reg_index     = rb;
                            r.reg_value     = nxt;
                            shadow_regs[rb] = nxt;
                            nxt             = shadow_regs[ra];
                        end
                        OP_HALT: begin
                            shadow_stopped = 1'b1;
                            r.status       = STAT_HALTED;
                        end
                        OP_NOOP: ;
                        default: r.status = STAT_UNKNOWN;
                    endcase
                    if (r.reg_written)
                        shadow_regs[r.reg_index] = r.reg_value;
                    shadow_pc = nxt[11:0];
                    if (shadow_count != '1)
                        shadow_count++;
                end
                status_tally[r.status]++;
            end
        endcase
        r.pc          = shadow_pc;
        r.instr_count = shadow_count;
        return r;
    endfunction

    // Check every strobed result against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_core_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, status", 32'(o_status), '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_pc !== want.pc)
                    report_mismatch("pc", 32'(o_pc), 32'(want.pc));
                if (o_read_data !== want.read_data)
                    report_mismatch("read_data", o_read_data, want.read_data);
                if (o_reg_written !== want.reg_written)
                    report_mismatch("reg_written", 32'(o_reg_written),
                                    32'(want.reg_written));
                if (o_reg_index !== want.reg_index)
                    report_mismatch("reg_index", 32'(o_reg_index), 32'(want.reg_index));
                if (o_reg_value !== want.reg_value)
                    report_mismatch("reg_value", o_reg_value, want.reg_value);
                if (o_mem_written !== want.mem_written)
                    report_mismatch("mem_written", 32'(o_mem_written),
                                    32'(want.mem_written));
                if (o_mem_addr !== want.mem_addr)
                    report_mismatch("mem_addr", 32'(o_mem_addr), 32'(want.mem_addr));
                if (o_instr_count !== want.instr_count)
                    report_mismatch("instr_count", o_instr_count, want.instr_count);
            end
        end
    end

    // Send one command transaction; hold start high until the core takes it.
    // Start stays high on return so back-to-back commands follow without a gap.
    task automatic issue_cmd(input logic [1:0] func, input logic [11:0] addr,
                             input logic [31:0] data);
        int gap;
        if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_func  <= func;
        i_addr  <= addr;
        i_data  <= data;
        do @(posedge i_clk); while (o_busy);
        pending_results.push_back(predict_core_step(func, addr, data));
        cmds_sent++;
    endtask

    // Drop start and hold off until every pending result has been checked
    task automatic pause_until_drained();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Write program_words over the register port while the core is idle,
    // then read it back.
    task automatic write_prog_words(input logic [12:0] value);
        pause_until_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PROG_WORDS, 2'b00};
        pwdata  <= {19'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_prog_words = value;
        length_writes++;
        // read-back: setup then access, psel stays high
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {19'd0, value})
            report_mismatch("program_words read-back", prdata, {19'd0, value});
        psel    <= 1'b0;
        penable <= 1'b0;
        // hold the port idle before anything else drives it
        @(posedge i_clk);
    endtask

    // Random instruction word with every operation except halt; other bits random bar one beq case
    function automatic logic [31:0] random_instruction();
        logic [31:0] word;
        logic [9:0]  op;
        word = $urandom;
        case ($urandom_range(0, 15))
            0, 1:   op = OP_ADD;
            2, 3:   op = OP_NOR;
            4, 5:   op = OP_LW;
            6, 7:   op = OP_SW;
            8, 9:   op = OP_BEQ;
            10: begin
                // same register on both sides: branch always taken
                op          = OP_BEQ;
                word[18:16] = word[21:19];
            end
            11, 12: op = OP_JALR;
            13:     op = OP_NOOP;
            default: op = 10'($urandom_range(8, 1023));
        endcase
        word[31:22] = op;
        return word;
    endfunction

    // Make sure the next execute fetches a written, non-halt word, and that an
    // lw reads a written word.
    task automatic ready_next_instruction();
        logic [31:0] word;
        logic [31:0] ea;
        if (shadow_stopped || {1'b0, shadow_pc} > shadow_prog_words)
            return;
        if (!shadow_mem_set[shadow_pc] || shadow_mem[shadow_pc][31:22] == OP_HALT)
            issue_cmd(FUNC_LOAD, shadow_pc, random_instruction());
        word = shadow_mem[shadow_pc];
        if (word[31:22] == OP_LW) begin
            ea = shadow_regs[word[21:19]] + {{16{word[15]}}, word[15:0]};
            if (!shadow_mem_set[ea[11:0]])
                issue_cmd(FUNC_LOAD, ea[11:0], $urandom);
        end
    endtask

    // Execute one instruction; raise program_words first if pc ran past it
    task automatic run_one_instruction();
        if (!shadow_stopped && {1'b0, shadow_pc} > shadow_prog_words)
            write_prog_words(13'($urandom_range(shadow_pc, 4096)));
        ready_next_instruction();
        issue_cmd(FUNC_EXEC, 12'($urandom), $urandom);
    endtask

    // Load a short program of random instructions at pc, then execute that many
    task automatic run_loaded_block();
        int          len;
        logic [11:0] at;
        len = $urandom_range(2, 8);
        at  = shadow_pc;
        for (int i = 0; i < len; i++)
            issue_cmd(FUNC_LOAD, at + 12'(i), random_instruction());
        for (int i = 0; i < len; i++)
            run_one_instruction();
    endtask

    // Loads, memory reads and register reads between instructions
    task automatic random_side_access();
        logic [11:0] a;
        a = 12'($urandom);
        case ($urandom_range(0, 2))
            0: issue_cmd(FUNC_LOAD, a, $urandom);
            1: begin
                if (!shadow_mem_set[a])
                    issue_cmd(FUNC_LOAD, a, $urandom);
                issue_cmd(FUNC_RDMEM, a, $urandom);
            end
            default: issue_cmd(FUNC_RDREG, a, $urandom);
        endcase
    endtask

    // Pick a new program length that keeps the current pc inside the program
    task automatic reprogram_length();
        case ($urandom_range(0, 2))
            0:       write_prog_words(13'd4096);
            1:       write_prog_words(13'd4095);
            default: write_prog_words(13'($urandom_range(shadow_pc, 4095)));
        endcase
    endtask

    // Register file and pc come out of reset at zero; then load two words and read one back
    task automatic test_reset_state();
        issue_cmd(FUNC_RDREG, 12'h000, 32'h0);
        issue_cmd(FUNC_RDREG, 12'hA05, 32'hFFFF_FFFF);
        issue_cmd(FUNC_LOAD, 12'd4095, 32'h7FFF_FFFF);
        issue_cmd(FUNC_LOAD, 12'd2048, 32'h8000_0000);
        issue_cmd(FUNC_RDMEM, 12'd2048, 32'h0);
    endtask

    // Hand-built program touching every operation but halt, offset extremes and address wrap
    task automatic test_directed_program();
        // lw with offset -1 from r0 wraps to the top word
        issue_cmd(FUNC_LOAD, 12'd0, encode(OP_LW, 3'd0, 3'd1, 16'hFFFF));
        issue_cmd(FUNC_LOAD, 12'd1, encode(OP_ADD, 3'd1, 3'd1, 16'd2));
        issue_cmd(FUNC_LOAD, 12'd2, encode(OP_NOR, 3'd2, 3'd0, 16'd3));
        // most negative offset on a large base lands on word 4094
        issue_cmd(FUNC_LOAD, 12'd3, encode(OP_SW, 3'd2, 3'd1, 16'h8000));
        issue_cmd(FUNC_LOAD, 12'd4, encode(OP_BEQ, 3'd1, 3'd2, 16'hFFFF));
        // jalr with the same register: link wins, jump to pc+1
        issue_cmd(FUNC_LOAD, 12'd5, encode(OP_JALR, 3'd6, 3'd6, 16'd0));
        issue_cmd(FUNC_LOAD, 12'd6, 32'hFFFF_FFFF);
        issue_cmd(FUNC_LOAD, 12'd7, encode(OP_NOOP, 3'd0, 3'd0, 16'd0));
        // jalr writing register zero, back to word 1
        issue_cmd(FUNC_LOAD, 12'd8, encode(OP_JALR, 3'd3, 3'd0, 16'd0));

        // shortest program: only word 0 may run
        write_prog_words(13'd0);
        issue_cmd(FUNC_EXEC, 12'hFFF, 32'hFFFF_FFFF);
        write_prog_words(13'd4096);
        repeat (8) issue_cmd(FUNC_EXEC, 12'($urandom), $urandom);

        issue_cmd(FUNC_RDREG, 12'hFFE, 32'h0);
        issue_cmd(FUNC_RDREG, 12'hFF8, 32'h0);
        issue_cmd(FUNC_RDMEM, 12'd4094, 32'h0);
    endtask

    // Random programs, side accesses and program length changes
    task automatic test_random_execution();
        int roll;
        int next_toggle;
        next_toggle = cmds_sent + 40;
        while (cmds_sent < 600) begin
            // re-pick at random, stretch by stretch, whether idle gaps are on
            if (cmds_sent >= next_toggle) begin
                gaps_enabled = ($urandom_range(0, 2) != 0);
                next_toggle  = cmds_sent + 40;
            end
            roll = $urandom_range(0, 99);
            if (roll < 45)
                run_one_instruction();
            else if (roll < 60)
                run_loaded_block();
            else if (roll < 63)
                reprogram_length();
            else
                random_side_access();
        end
    endtask

    // Stop the core once, by halt or by pc passing the program end, then keep
    // sending commands: executes must answer stopped, the rest must still work.
    task automatic test_program_stop();
        gaps_enabled = 1'b0;
        if ($urandom_range(0, 1) == 1) begin
            if ({1'b0, shadow_pc} > shadow_prog_words)
                write_prog_words(13'd4096);
            issue_cmd(FUNC_LOAD, shadow_pc, {OP_HALT, 22'($urandom)});
            issue_cmd(FUNC_EXEC, 12'($urandom), $urandom);
        end else begin
            while (shadow_pc == 12'd0)
                run_one_instruction();
            write_prog_words(13'($urandom_range(0, int'(shadow_pc) - 1)));
            issue_cmd(FUNC_EXEC, 12'($urandom), $urandom);
        end
        repeat (40) begin
            if ($urandom_range(0, 2) == 0)
                issue_cmd(FUNC_EXEC, 12'($urandom), $urandom);
            else
                random_side_access();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // shadow state matches the core right after reset
        for (int i = 0; i < NUM_REGS; i++)
            shadow_regs[i] = '0;
        for (int i = 0; i < MEM_WORDS; i++) begin
            shadow_mem[i]     = '0;
            shadow_mem_set[i] = 1'b0;
        end
        shadow_pc         = '0;
        shadow_stopped    = 1'b0;
        shadow_count      = '0;
        shadow_prog_words = '0;

        test_reset_state();
        test_directed_program();
        test_random_execution();
        test_program_stop();

        // drain, then keep watching for any stray strobe
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d transactions and %0d program length writes in %0d cycles.",
                 cmds_sent, length_writes, cycle_count);
        $display("Executes: ok %0d, halted %0d, unknown opcode %0d, stopped %0d, past end %0d.",
                 status_tally[STAT_OK], status_tally[STAT_HALTED],
                 status_tally[STAT_UNKNOWN], status_tally[STAT_STOPPED],
                 status_tally[STAT_PAST_END]);
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", fault_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: lc2k_instruction_executor.f
rtl/core/lc2k_pkg.sv
rtl/core/lc2k_word_mem.sv
rtl/core/lc2k_reg_file.sv
rtl/core/lc2k_instruction_executor.sv
test/testbench.sv
